[design/pcbd_pkg.sv]
// Package: payload types, field widths and status codes of the per-class deque bank.
`timescale 1ns / 1ps
package pcbd_pkg;

  localparam int ID_W    = 16;
  localparam int CLS_W   = 5;
  localparam int LIM_W   = 4;
  localparam int CNT_W   = 4;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TAKEN = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic             mode;
    logic [CLS_W-1:0] class_index;
    logic             urgent;
    logic [ID_W-1:0]  item_id;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   taken_id;
    logic              taken_urgent;
    logic [CNT_W-1:0]  class_count;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     oor;
  } op_t;

endpackage

[design/pcbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/pcbd_front.sv]
// Front end: accept operations, flag out-of-range classes, buffer them in a two-entry queue.
`timescale 1ns / 1ps
module pcbd_front import pcbd_pkg::*; #(
  parameter int NUM_CLASSES = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output op_t      q_data,
  input  logic     q_pop
);

  op_t        q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  op_t        op_in;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem_r[rd_ptr_r];

  always_comb begin
    op_in.item = in_data;
    op_in.oor  = (int'(in_data.class_index) >= NUM_CLASSES);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

[design/pcbd_back.sv]
// Back end: per-class head and count lookup, entry store access, result register.
`timescale 1ns / 1ps
module pcbd_back import pcbd_pkg::*; #(
  parameter int NUM_CLASSES = 32,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LIM_W-1:0] queue_limit,
  input  logic             q_valid,
  input  op_t              q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MW  = PW + CW;
  localparam int EW  = ID_W + 1;
  localparam int NE  = NUM_CLASSES * QUEUE_DEPTH;
  localparam int EAW = (NE > 1) ? $clog2(NE) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]             state_r, state_nxt;
  op_t                    op_r;
  logic [CW-1:0]          cnt_hold_r;
  logic [NUM_CLASSES-1:0] vld_r;
  logic                   out_valid_r;
  out_item_t              out_item_r, out_item_nxt;
  logic                   out_load, out_free;

  logic [CLW-1:0] cls_idx, rd_cls_idx;
  logic [MW-1:0]  meta_rdata, meta_wdata;
  logic           meta_we;
  logic [PW-1:0]  head, head_inc, head_dec, head_new, slot;
  logic [PW:0]    tail_sum;
  logic [CW-1:0]  n, n_new;
  logic           full, add_ok, take_hit, proceed;
  logic [EAW-1:0] ent_base, ent_addr;
  logic           ent_we, ent_re;
  logic [EW-1:0]  ent_rdata;

  assign cls_idx    = CLW'(op_r.item.class_index);
  assign rd_cls_idx = CLW'(q_data.item.class_index);
  assign out_free   = !out_valid_r || out_ready;
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  pcbd_ram #(.WIDTH(MW), .DEPTH(NUM_CLASSES), .AW(CLW)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (cls_idx),
    .wdata (meta_wdata),
    .re    (q_pop),
    .raddr (rd_cls_idx),
    .rdata (meta_rdata)
  );

  pcbd_ram #(.WIDTH(EW), .DEPTH(NE), .AW(EAW)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_addr),
    .wdata ({op_r.item.urgent, op_r.item.item_id}),
    .re    (ent_re),
    .raddr (ent_addr),
    .rdata (ent_rdata)
  );

  always_comb begin
    head = vld_r[cls_idx] ? meta_rdata[MW-1:CW] : '0;
    n    = vld_r[cls_idx] ? meta_rdata[CW-1:0] : '0;

    head_inc = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
    head_dec = (head == '0) ? PW'(QUEUE_DEPTH - 1) : head - PW'(1);
    tail_sum = {1'b0, head} + (PW + 1)'(n);
    if (tail_sum >= (PW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (PW + 1)'(QUEUE_DEPTH);
    end

    full     = (int'(n) >= int'(queue_limit)) || (int'(n) >= QUEUE_DEPTH);
    add_ok   = !op_r.oor && (op_r.item.mode == MODE_ADD) && !full;
    take_hit = !op_r.oor && (op_r.item.mode == MODE_TAKE) && (n != '0);

    head_new = head;
    slot     = head;
    n_new    = n;
    if (add_ok) begin
      n_new = n + CW'(1);
      if (op_r.item.urgent) begin
        head_new = head_dec;
        slot     = head_dec;
      end else begin
        slot = tail_sum[PW-1:0];
      end
    end else if (take_hit) begin
      head_new = head_inc;
      n_new    = n - CW'(1);
    end

    ent_base   = EAW'(cls_idx) * EAW'(QUEUE_DEPTH);
    ent_addr   = ent_base + EAW'(slot);
    meta_wdata = {head_new, n_new};

    proceed = (state_r == S_META) && (take_hit || out_free);
    meta_we = proceed && (add_ok || take_hit);
    ent_we  = proceed && add_ok;
    ent_re  = (state_r == S_META) && take_hit;
  end

  always_comb begin
    state_nxt    = state_r;
    out_load     = 1'b0;
    out_item_nxt = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        if (take_hit) begin
          state_nxt = S_DATA;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (op_r.oor) begin
            out_item_nxt.status = (op_r.item.mode == MODE_TAKE) ? ST_EMPTY : ST_FULL;
          end else begin
            if (op_r.item.mode == MODE_TAKE) begin
              out_item_nxt.status = ST_EMPTY;
            end else begin
              out_item_nxt.status = add_ok ? ST_ADDED : ST_FULL;
            end
            out_item_nxt.class_count = CNT_W'(n_new);
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_load                  = 1'b1;
          state_nxt                 = S_IDLE;
          out_item_nxt.status       = ST_TAKEN;
          out_item_nxt.taken_id     = ent_rdata[ID_W-1:0];
          out_item_nxt.taken_urgent = ent_rdata[ID_W];
          out_item_nxt.class_count  = CNT_W'(cnt_hold_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (meta_we) begin
        vld_r[cls_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_data;
    end
    if (ent_re) begin
      cnt_hold_r <= n_new;
    end
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_data_after_meta: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> ($past(state_r) == S_META || $past(state_r) == S_DATA))
    else $error("entry read stage entered without lookup");

  a_taken_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA && out_free) |=> (out_valid_r && out_item_r.status == ST_TAKEN))
    else $error("taken result not delivered from entry read");

  a_meta_write_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (meta_we || ent_we) |-> (state_r == S_META && !op_r.oor))
    else $error("store written outside lookup stage or for bad class");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten while held");

endmodule

[design/per_class_bounded_deque_top.sv]
// Top level: per-class bounded deque bank with limit register, front queue and back end.
//
//  channel | ports                          | transfer
//  --------+--------------------------------+-----------------------------------
//  in      | in_valid, in_ready, in_data    | one add or take operation
//  out     | out_valid, out_ready, out_data | one result per operation, in order
//  cfg     | cfg_valid, cfg_ready, cfg_data | queue_limit write, always ready
//
//  In the back end, an add, a rejected add or an empty take passes through the registered
//  read of the head/count RAM only; a take that finds an entry passes through that read,
//  then the registered read of the entry RAM. The front queue holds two operations.
//  Reset clears per-class valid flops at once; no clearing pass, entry store is not reset.
//  A held result stalls the back end only; the front keeps accepting until its queue fills.
`timescale 1ns / 1ps
module per_class_bounded_deque_top import pcbd_pkg::*; #(
  parameter int NUM_CLASSES = 32,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LIM_W-1:0] cfg_data
);

  logic [LIM_W-1:0] queue_limit_r;
  logic             q_valid, q_pop;
  op_t              q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      queue_limit_r <= cfg_data;
    end
  end

  pcbd_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  pcbd_back #(.NUM_CLASSES(NUM_CLASSES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_limit (queue_limit_r),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

[verif/pcbd_checker.sv]
// Checker: watches the channels, predicts each deque bank result and compares it.
`timescale 1ns / 1ps
module pcbd_checker import pcbd_pkg::*; #(
  parameter int NUM_CLASSES = 32,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LIM_W-1:0] cfg_data,
  output int               outstanding,
  output int               errors
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [ID_W:0]      slot_mem   [NUM_CLASSES*QUEUE_DEPTH];
  logic [PTR_W-1:0]   head_slot  [NUM_CLASSES];
  logic [CNT_W-1:0]   fill_count [NUM_CLASSES];
  logic [LIM_W-1:0]   limit_reg;
  out_item_t          pending_results [$];

  out_item_t          want;
  logic [LIM_W-1:0]   eff_limit;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   slot;
  logic [CNT_W-1:0]   fill;
  logic [ID_W:0]      entry;
  int                 cls;

  task automatic check_field(input string name, input logic [ID_W-1:0] exp_v,
                             input logic [ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_slot[c]  = '0;
        fill_count[c] = '0;
      end
      limit_reg = LIMIT_RESET;
      errors    = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("status", ID_W'(want.status), ID_W'(out_data.status));
          check_field("taken_id", want.taken_id, out_data.taken_id);
          check_field("taken_urgent", ID_W'(want.taken_urgent),
                      ID_W'(out_data.taken_urgent));
          check_field("class_count", ID_W'(want.class_count),
                      ID_W'(out_data.class_count));
        end
      end

      if (in_valid && in_ready) begin
        want = '0;
        cls  = int'(in_data.class_index);
        eff_limit = (limit_reg > QUEUE_DEPTH) ? LIM_W'(QUEUE_DEPTH) : limit_reg;
        if (cls >= NUM_CLASSES) begin
          want.status = (in_data.mode == MODE_TAKE) ? ST_EMPTY : ST_FULL;
        end else begin
          head = head_slot[cls];
          fill = fill_count[cls];
          if (in_data.mode == MODE_ADD) begin
            if (fill >= eff_limit) begin
              want.status = ST_FULL;
            end else begin
              if (in_data.urgent) begin
                head = PTR_W'((head + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
                slot = head;
                head_slot[cls] = head;
              end else begin
                slot = PTR_W'((head + fill) % QUEUE_DEPTH);
              end
              slot_mem[cls*QUEUE_DEPTH + slot] = {in_data.urgent, in_data.item_id};
              fill = fill + 1'b1;
              fill_count[cls] = fill;
              want.status = ST_ADDED;
            end
          end else if (fill == 0) begin
            want.status = ST_EMPTY;
          end else begin
            entry = slot_mem[cls*QUEUE_DEPTH + head];
            want.taken_id     = entry[ID_W-1:0];
            want.taken_urgent = entry[ID_W];
            head_slot[cls] = PTR_W'((head + 1) % QUEUE_DEPTH);
            fill = fill - 1'b1;
            fill_count[cls] = fill;
            want.status = ST_TAKEN;
          end
          want.class_count = fill;
        end
        pending_results.push_back(want);
      end

      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
    end
    outstanding <= pending_results.size();
  end

endmodule

[verif/per_class_bounded_deque_top_test.sv]
// Testbench top: drives operations and limit writes into the deque bank and gives the verdict.
`timescale 1ns / 1ps
module per_class_bounded_deque_top_test;
  import pcbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LIM_W-1:0] cfg_data  = '0;
  logic             calm      = 1'b0;
  int               outstanding;
  int               errors;
  int               cycle_count = 0;

  per_class_bounded_deque_top #(
    .NUM_CLASSES(32),
    .QUEUE_DEPTH(8)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  pcbd_checker #(
    .NUM_CLASSES(32),
    .QUEUE_DEPTH(8)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .errors     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_op(input logic m, input logic [CLS_W-1:0] c, input logic u,
                         input logic [ID_W-1:0] id);
    in_item_t op;
    op.mode        = m;
    op.class_index = c;
    op.urgent      = u;
    op.item_id     = id;
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] v);
    wait_quiet();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [LIM_W-1:0] phase_limit [PHASES];
    logic [CLS_W-1:0] hot [3];
    logic [CLS_W-1:0] cls;
    logic [LIM_W-1:0] lim_v;
    int               take_pct;

    phase_limit = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd3, 4'd6};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: fill one class past the limit, then drain it
    send_op(MODE_TAKE, 5'd0, 1'b0, 16'h0000);
    send_op(MODE_ADD,  5'd0, 1'b0, 16'h0000);
    send_op(MODE_ADD,  5'd0, 1'b1, 16'hFFFF);
    send_op(MODE_ADD,  5'd0, 1'b0, 16'h1234);
    send_op(MODE_ADD,  5'd0, 1'b1, 16'h8001);
    send_op(MODE_ADD,  5'd0, 1'b0, 16'h7FFE);
    send_op(MODE_ADD,  5'd0, 1'b1, 16'hBEEF);
    repeat (6) send_op(MODE_TAKE, 5'd0, 1'b1, 16'hFFFF);
    send_op(MODE_ADD,  5'd31, 1'b1, 16'hAAAA);
    send_op(MODE_ADD,  5'd31, 1'b0, 16'h5555);
    repeat (3) send_op(MODE_TAKE, 5'd31, 1'b0, 16'h0000);

    // zero limit rejects every add
    write_limit(4'd0);
    send_op(MODE_ADD,  5'd5, 1'b0, 16'h0F0F);
    send_op(MODE_ADD,  5'd5, 1'b1, 16'hF0F0);
    send_op(MODE_TAKE, 5'd5, 1'b0, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      lim_v = (p == PHASES - 1) ? LIM_W'($urandom_range(1, 8)) : phase_limit[p];
      write_limit(lim_v);
      for (int h = 0; h < 3; h++) hot[h] = CLS_W'($urandom_range(0, 31));
      if (p == 2) calm <= 1'b1;
      take_pct = 50;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) take_pct = $urandom_range(15, 85);
        if (i == PHASE_ITEMS / 2) wait_quiet();
        cls = ($urandom_range(0, 99) < 75) ? hot[$urandom_range(0, 2)]
                                           : CLS_W'($urandom_range(0, 31));
        send_op(($urandom_range(0, 99) < take_pct) ? MODE_TAKE : MODE_ADD, cls,
                1'($urandom_range(0, 1)), ID_W'($urandom()));
      end
      calm <= 1'b0;
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/pcbd_pkg.sv
design/pcbd_ram.sv
design/pcbd_front.sv
design/pcbd_back.sv
design/per_class_bounded_deque_top.sv
verif/pcbd_checker.sv
verif/per_class_bounded_deque_top_test.sv
